[src/rpfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfa_pkg
// Shared types and constants of the reference-counted page frame allocator.
// ----------------------------------------------------------------------------
package rpfa_pkg;

  localparam int unsigned DefPageCount = 32768;
  localparam int unsigned DefPageBytes = 4096;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 8;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_REF   = 3'd3,
    OP_QUERY = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    CFG_START = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic accept;
    logic start_init;
    logic init_step;
    logic check;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_req;
    logic init_more;
  } dp_status_t;

endpackage

[src/rpfa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfa_ctrl
// Sequencer of the allocator: steps each operation but init through check, lookup and
// update, runs the init walk and owns the result valid flag.
// ----------------------------------------------------------------------------
module rpfa_ctrl
  import rpfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_INIT   = 5'b01000,
    S_UPDATE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.start_init = cmd_o.accept && status_i.init_req;
    cmd_o.init_step  = (state_q == S_INIT) && status_i.init_more;
    cmd_o.check      = (state_q == S_CHECK);
    cmd_o.lookup     = (state_q == S_LOOKUP);
    cmd_o.commit     = (state_q == S_UPDATE) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.init_req ? S_INIT : S_CHECK;
        end
      end
      S_CHECK:  state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_UPDATE;
      S_INIT: begin
        if (!status_i.init_more) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_no_commit_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.commit)
    else $error("result overwritten while stalled");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed result not presented");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> !in_ready_o)
    else $error("second transfer taken while busy");
`endif

endmodule

[src/rpfa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfa_datapath
// Window registers, address check, free stack and count memories, and the
// result register of the allocator.
// ----------------------------------------------------------------------------
module rpfa_datapath
  import rpfa_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = DefPageCount,
  parameter int unsigned PAGE_BYTES = DefPageBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [AddrW-1:0]  cfg_data_i,
  input  logic [2:0]        in_operation_i,
  input  logic [AddrW-1:0]  in_address_i,
  output logic [AddrW-1:0]  out_page_address_o,
  output logic [CountW-1:0] out_ref_count_o,
  output logic              out_released_o,
  output logic [1:0]        out_status_o,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o
);

  localparam int unsigned IdxW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned DepthW = $clog2(PAGE_COUNT + 1);
  localparam int unsigned OffW   = $clog2(PAGE_BYTES);
  localparam int unsigned RelW   = AddrW + 1 - OffW;
  localparam logic [DepthW-1:0] DepthMax = DepthW'(PAGE_COUNT);
  localparam logic [AddrW+1:0]  PageStep = (AddrW+2)'(PAGE_BYTES);

  logic [IdxW-1:0]   free_stack [PAGE_COUNT];
  logic [CountW-1:0] ref_counts [PAGE_COUNT];

  logic [AddrW-1:0]  start_q, limit_q;
  logic [2:0]        op_q;
  logic [AddrW-1:0]  addr_q;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [AddrW+1:0]  walk_q;
  logic              aligned_q, above_q, fits_q, valid_q;
  logic [RelW-1:0]   rel_q;
  logic [IdxW-1:0]   idx_q;
  logic [IdxW-1:0]   stk_rdata_q;
  logic [CountW-1:0] cnt_rdata_q;

  logic [AddrW:0]    base;
  logic [RelW-1:0]   base_page;
  logic [DepthW-1:0] depth_dec;
  logic [31:0]       rel_ext;
  logic [IdxW-1:0]   lookup_idx;
  logic [AddrW:0]    idx_offset;
  logic [AddrW:0]    alloc_addr;

  logic              cnt_we, stk_we;
  logic [IdxW-1:0]   cnt_waddr, stk_waddr, stk_wdata;
  logic [CountW-1:0] cnt_wdata;
  logic [AddrW-1:0]  res_page;
  logic [CountW-1:0] res_count;
  logic              res_released;
  status_e           res_status;

  // window base, rounded up to a page boundary, may reach 2^32
  assign base_page = RelW'(start_q[AddrW-1:OffW]) + RelW'(|start_q[OffW-1:0]);
  assign base      = {base_page, {OffW{1'b0}}};
  assign depth_dec = depth_q - DepthW'(1);
  assign rel_ext   = 32'(rel_q);
  assign lookup_idx = (op_q == OP_ALLOC) ? stk_rdata_q : rel_ext[IdxW-1:0];
  assign idx_offset = (AddrW+1)'({idx_q, {OffW{1'b0}}});
  assign alloc_addr = base + idx_offset;

  assign status_o.init_req  = (in_operation_i == OP_INIT);
  assign status_o.init_more = (depth_q < DepthMax) &&
                              ((walk_q + PageStep) <= {2'b00, limit_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 32'h8000_0000;
      limit_q <= 32'h8800_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START: start_q <= cfg_data_i;
        CFG_LIMIT: limit_q <= cfg_data_i;
        default:   start_q <= start_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_operation_i;
      addr_q <= in_address_i;
    end
    if (cmd_i.start_init) begin
      walk_q <= {1'b0, base};
    end else if (cmd_i.init_step) begin
      walk_q <= walk_q + PageStep;
    end
    if (cmd_i.check) begin
      aligned_q <= (addr_q[OffW-1:0] == '0);
      above_q   <= ({1'b0, addr_q} >= base);
      fits_q    <= (({1'b0, addr_q} + (AddrW+1)'(PAGE_BYTES)) <= {1'b0, limit_q});
      rel_q     <= RelW'(addr_q[AddrW-1:OffW]) - base_page;
    end
    if (cmd_i.lookup) begin
      valid_q     <= aligned_q && above_q && fits_q && (rel_ext < 32'(PAGE_COUNT));
      idx_q       <= lookup_idx;
      cnt_rdata_q <= ref_counts[lookup_idx];
    end
    stk_rdata_q <= free_stack[depth_dec[IdxW-1:0]];
    if (stk_we) begin
      free_stack[stk_waddr] <= stk_wdata;
    end
    if (cnt_we) begin
      ref_counts[cnt_waddr] <= cnt_wdata;
    end
    if (cmd_i.commit) begin
      out_page_address_o <= res_page;
      out_ref_count_o    <= res_count;
      out_released_o     <= res_released;
      out_status_o       <= res_status;
    end
  end

  always_comb begin
    depth_d      = depth_q;
    cnt_we       = 1'b0;
    cnt_waddr    = idx_q;
    cnt_wdata    = '0;
    stk_we       = 1'b0;
    stk_waddr    = depth_q[IdxW-1:0];
    stk_wdata    = idx_q;
    res_page     = '0;
    res_count    = '0;
    res_released = 1'b0;
    res_status   = ST_OK;

    if (cmd_i.start_init) begin
      depth_d = '0;
    end

    // init walk: page n sits at stack slot n with a count of zero
    if (cmd_i.init_step) begin
      cnt_we    = 1'b1;
      cnt_waddr = depth_q[IdxW-1:0];
      stk_we    = 1'b1;
      stk_wdata = depth_q[IdxW-1:0];
      depth_d   = depth_q + DepthW'(1);
    end

    if (cmd_i.commit) begin
      unique case (op_q)
        OP_ALLOC: begin
          if (depth_q == '0) begin
            res_status = ST_NO_FREE;
          end else begin
            depth_d   = depth_dec;
            cnt_we    = 1'b1;
            cnt_wdata = CountW'(1);
            res_page  = alloc_addr[AddrW-1:0];
            res_count = CountW'(1);
          end
        end
        OP_FREE: begin
          if (!valid_q) begin
            res_status = ST_BAD_ADDR;
          end else if (cnt_rdata_q == '0) begin
            res_status = ST_UNDERFLOW;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rdata_q - CountW'(1);
            res_count = cnt_rdata_q - CountW'(1);
            if ((cnt_rdata_q == CountW'(1)) && (depth_q < DepthMax)) begin
              stk_we       = 1'b1;
              depth_d      = depth_q + DepthW'(1);
              res_released = 1'b1;
            end
          end
        end
        OP_REF: begin
          if (!valid_q) begin
            res_status = ST_BAD_ADDR;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = (cnt_rdata_q == '1) ? cnt_rdata_q : cnt_rdata_q + CountW'(1);
            res_count = cnt_wdata;
          end
        end
        OP_QUERY: begin
          if (!valid_q) begin
            res_status = ST_BAD_ADDR;
          end else begin
            res_count = cnt_rdata_q;
          end
        end
        default: res_status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthMax)
    else $error("free stack depth beyond page count");

  a_alloc_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == OP_ALLOC) && (depth_q != '0))
      |=> (depth_q == $past(depth_dec)))
    else $error("alloc did not pop the free stack");

  a_release_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && res_released) |=> (depth_q == $past(depth_q) + DepthW'(1)))
    else $error("released page not pushed");
`endif

endmodule

[src/refcounted_page_frame_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// Page frame allocator with a LIFO free stack and per-page reference counts.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we_i                  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o   in_operation_i, in_address_i
//   out      out        out_valid_o / out_ready_i page_address, ref_count,
//                                                 released, status
//
// alloc, free, reference up, query and unused codes: each transfer steps through
// accept, address check, registered count-table read, update and result
// init: accept, one stack and count write a cycle per managed page, then result
// reset clears the stack depth and sets the default window; the memories need no clearing pass
// a stalled result holds the update step; the next transfer is taken as soon
// as the result sits in the output register
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator
  import rpfa_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = DefPageCount,
  parameter int unsigned PAGE_BYTES = DefPageBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [AddrW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        in_operation_i,
  input  logic [AddrW-1:0]  in_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [AddrW-1:0]  out_page_address_o,
  output logic [CountW-1:0] out_ref_count_o,
  output logic              out_released_o,
  output logic [1:0]        out_status_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  rpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  rpfa_datapath #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_operation_i     (in_operation_i),
    .in_address_i       (in_address_i),
    .out_page_address_o (out_page_address_o),
    .out_ref_count_o    (out_ref_count_o),
    .out_released_o     (out_released_o),
    .out_status_o       (out_status_o),
    .cmd_i              (cmd),
    .status_o           (dp_status)
  );

endmodule

[dv/refcounted_page_frame_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_tb
// Self-checking bench for the page frame allocator. A directed table covers
// the reset window, the error codes, underflow and a free with the stack full.
// Random traffic then runs over a series of address windows under several
// pacing schemes. Every result is compared against a cycle-free model of the
// free stack and the per-page reference counts.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_tb;
  import rpfa_pkg::*;

  localparam int unsigned PAGES = DefPageCount;
  localparam int unsigned PB = DefPageBytes;
  localparam int unsigned IdxW = $clog2(DefPageCount);
  localparam int unsigned QUIET_LIMIT = 150000;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic [31:0] TOP_PAGE = 32'h87FF_F000;
  localparam logic [31:0] NEXT_PAGE = 32'h87FF_E000;
  localparam logic [31:0] FIRST_PAGE = 32'h8000_0000;

  typedef logic [AddrW:0] span_t;

  typedef struct packed {
    logic [AddrW-1:0]  page_address;
    logic [CountW-1:0] ref_count;
    logic              released;
    status_e           status;
  } reply_t;

  typedef struct {
    logic [2:0]       op;
    logic [AddrW-1:0] addr;
    bit               typed;
    reply_t           want;
  } probe_t;

  typedef struct {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] limit;
    bit               rebuild;
    int unsigned      items;
  } window_t;

  localparam reply_t R_OK = '{32'h0, 8'd0, 1'b0, ST_OK};
  localparam reply_t R_BAD = '{32'h0, 8'd0, 1'b0, ST_BAD_ADDR};

  localparam int unsigned NPROBE = 21;
  localparam int unsigned NWIN = 8;

  probe_t probe_tab [NPROBE] = '{
    '{OP_ALLOC,    32'h0000_0000, 1'b1, '{32'h0, 8'd0, 1'b0, ST_NO_FREE}},
    '{OP_QUERY,    32'h7FFF_F000, 1'b1, R_BAD},
    '{OP_FREE,     32'h8000_0001, 1'b1, R_BAD},
    '{OP_REF,      32'h8800_0000, 1'b1, R_BAD},
    '{OP_SPARE_LO, 32'hFFFF_FFFF, 1'b1, R_OK},
    '{OP_SPARE_HI, 32'h0000_0000, 1'b1, R_OK},
    '{OP_INIT,     32'hA5A5_5A5A, 1'b1, R_OK},
    '{OP_ALLOC,    32'h0000_0000, 1'b1, '{TOP_PAGE, 8'd1, 1'b0, ST_OK}},
    '{OP_ALLOC,    32'hFFFF_FFFF, 1'b1, '{NEXT_PAGE, 8'd1, 1'b0, ST_OK}},
    '{OP_QUERY,    TOP_PAGE,      1'b1, '{32'h0, 8'd1, 1'b0, ST_OK}},
    '{OP_REF,      TOP_PAGE,      1'b0, R_OK},
    '{OP_FREE,     TOP_PAGE,      1'b0, R_OK},
    '{OP_FREE,     TOP_PAGE,      1'b1, '{32'h0, 8'd0, 1'b1, ST_OK}},
    '{OP_FREE,     TOP_PAGE,      1'b1, '{32'h0, 8'd0, 1'b0, ST_UNDERFLOW}},
    '{OP_FREE,     NEXT_PAGE,     1'b0, R_OK},
    '{OP_REF,      FIRST_PAGE,    1'b0, R_OK},
    '{OP_FREE,     FIRST_PAGE,    1'b1, R_OK},
    '{OP_ALLOC,    32'h5A5A_A5A5, 1'b0, R_OK},
    '{OP_QUERY,    FIRST_PAGE,    1'b1, R_OK},
    '{OP_REF,      32'hFFFF_F000, 1'b1, R_BAD},
    '{OP_QUERY,    32'h87FF_F800, 1'b1, R_BAD}
  };

  window_t windows [NWIN] = '{
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 170},
    '{32'h0000_0000, 32'h0000_2000, 1'b1, 170},
    '{32'hFFFF_C001, 32'hFFFF_FFFF, 1'b1, 170},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 30},
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 30},
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 170},
    '{32'h8000_0000, 32'h8003_0000, 1'b0, 170},
    '{32'h4000_0001, 32'h4002_107C, 1'b1, 170}
  };

  int unsigned idle_by_phase [4] = '{0, 61, 0, 22};
  int unsigned stall_by_phase [4] = '{0, 0, 61, 22};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = CFG_START;
  logic [AddrW-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        in_operation_i = OP_INIT;
  logic [AddrW-1:0]  in_address_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [AddrW-1:0]  out_page_address_o;
  logic [CountW-1:0] out_ref_count_o;
  logic              out_released_o;
  logic [1:0]        out_status_o;

  // model of the frame bookkeeping
  logic [AddrW-1:0]  cfg_start = 32'h8000_0000;
  logic [AddrW-1:0]  cfg_limit = 32'h8800_0000;
  logic [IdxW-1:0]   free_frames [PAGES];
  logic [IdxW:0]     free_depth = '0;
  logic [CountW-1:0] frame_refs [PAGES];
  bit                refs_valid [PAGES];
  logic [IdxW-1:0]   live_frames [$];

  reply_t      awaited [$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  refcounted_page_frame_allocator DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_operation_i     (in_operation_i),
    .in_address_i       (in_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_page_address_o (out_page_address_o),
    .out_ref_count_o    (out_ref_count_o),
    .out_released_o     (out_released_o),
    .out_status_o       (out_status_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic span_t window_base();
    return (({1'b0, cfg_start} + PB - 1) / PB) * PB;
  endfunction

  function automatic int unsigned window_pages();
    span_t base;
    span_t n;
    base = window_base();
    if (base + PB > {1'b0, cfg_limit}) return 0;
    n = ({1'b0, cfg_limit} - base) / PB;
    return (n > PAGES) ? PAGES : int'(n);
  endfunction

  function automatic logic [AddrW-1:0] frame_addr(input logic [IdxW-1:0] idx);
    return AddrW'(window_base() + span_t'(idx) * PB);
  endfunction

  function automatic bit page_slot(input logic [AddrW-1:0] addr,
                                   output logic [IdxW-1:0] idx);
    span_t base;
    span_t rel;
    base = window_base();
    idx = '0;
    if (addr % PB != 0) return 0;
    if ({1'b0, addr} < base) return 0;
    if ({1'b0, addr} + PB > {1'b0, cfg_limit}) return 0;
    rel = ({1'b0, addr} - base) / PB;
    if (rel >= PAGES) return 0;
    idx = IdxW'(rel);
    return 1;
  endfunction

  function automatic reply_t apply_to_frames(input logic [2:0] op,
                                             input logic [AddrW-1:0] addr);
    reply_t r;
    logic [IdxW-1:0] idx;
    int unsigned n;
    bit hit;
    r = '0;
    hit = page_slot(addr, idx);
    case (op)
      OP_INIT: begin
        n = window_pages();
        for (int unsigned i = 0; i < n; i++) begin
          frame_refs[IdxW'(i)] = '0;
          refs_valid[IdxW'(i)] = 1'b1;
          free_frames[IdxW'(i)] = IdxW'(i);
        end
        free_depth = (IdxW + 1)'(n);
        live_frames.delete();
      end
      OP_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_NO_FREE;
        end else begin
          free_depth--;
          idx = free_frames[free_depth[IdxW-1:0]];
          frame_refs[idx] = 8'd1;
          refs_valid[idx] = 1'b1;
          live_frames.push_back(idx);
          r.page_address = frame_addr(idx);
          r.ref_count = 8'd1;
        end
      end
      OP_FREE: begin
        if (!hit) begin
          r.status = ST_BAD_ADDR;
        end else if (frame_refs[idx] == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          frame_refs[idx]--;
          r.ref_count = frame_refs[idx];
          // a page freed with the stack full keeps its zero count but stays off the stack
          if (frame_refs[idx] == 0 && free_depth < PAGES) begin
            free_frames[free_depth[IdxW-1:0]] = idx;
            free_depth++;
            r.released = 1'b1;
          end
        end
      end
      OP_REF: begin
        if (!hit) begin
          r.status = ST_BAD_ADDR;
        end else begin
          if (frame_refs[idx] != 8'hFF) frame_refs[idx]++;
          r.ref_count = frame_refs[idx];
        end
      end
      OP_QUERY: begin
        if (!hit) r.status = ST_BAD_ADDR;
        else r.ref_count = frame_refs[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] page_op();
    case ($urandom_range(2))
      0: return OP_FREE;
      1: return OP_REF;
      default: return OP_QUERY;
    endcase
  endfunction

  task automatic random_item(output logic [2:0] op, output logic [AddrW-1:0] addr);
    int unsigned roll;
    int unsigned n;
    int unsigned k;
    logic [IdxW-1:0] idx;
    n = window_pages();
    roll = $urandom_range(99);
    addr = $urandom();
    op = OP_QUERY;
    if (roll < 24) begin
      op = OP_ALLOC;
    end else if (roll < 70) begin
      op = (roll < 48) ? OP_FREE : ((roll < 62) ? OP_REF : OP_QUERY);
      if (live_frames.size() != 0) begin
        k = $urandom_range(live_frames.size() - 1);
        idx = live_frames[k];
        if (idx < n && frame_refs[idx] != 0) addr = frame_addr(idx);
        else live_frames.delete(k);
      end
    end else if (roll < 78) begin
      // any page of the window, free ones included
      op = page_op();
      if (n != 0) addr = frame_addr(IdxW'($urandom_range(n - 1)));
    end else if (roll < 92) begin
      op = page_op();
      case ($urandom_range(3))
        0: if (n != 0) addr = frame_addr(IdxW'($urandom_range(n - 1))) + $urandom_range(1, PB - 1);
        1: addr = AddrW'(window_base() - PB * $urandom_range(1, 4));
        2: addr = cfg_limit & ~(PB - 1);
        default: ;
      endcase
    end else if (roll < 96) begin
      op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    end else if (roll < 98 && n <= 64) begin
      op = OP_INIT;
    end
    // never touch a page whose count has not been written yet
    if ((op == OP_FREE || op == OP_REF || op == OP_QUERY) && page_slot(addr, idx)
        && !refs_valid[idx])
      addr = addr | 32'h1;
  endtask

  task automatic push_item(input logic [2:0] op, input logic [AddrW-1:0] addr,
                           input bit typed, input reply_t want);
    reply_t got;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_operation_i <= op;
    in_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    got = apply_to_frames(op, addr);
    awaited.push_back(typed ? want : got);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [AddrW-1:0] start, input logic [AddrW-1:0] limit);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_START;
    cfg_data_i <= start;
    @(posedge clk_i);
    cfg_index_i <= CFG_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_start = start;
    cfg_limit = limit;
  endtask

  task automatic report(input string field, input logic [AddrW-1:0] want,
                        input logic [AddrW-1:0] got);
    $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (out_page_address_o !== want.page_address)
          report("page_address", want.page_address, out_page_address_o);
        if (out_ref_count_o !== want.ref_count)
          report("ref_count", AddrW'(want.ref_count), AddrW'(out_ref_count_o));
        if (out_released_o !== want.released)
          report("released", AddrW'(want.released), AddrW'(out_released_o));
        if (out_status_o !== want.status)
          report("status", AddrW'(want.status), AddrW'(out_status_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0] op;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] hot;
    logic [1:0] phase;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_tab[i])
      push_item(probe_tab[i].op, probe_tab[i].addr, probe_tab[i].typed, probe_tab[i].want);

    windows[5].start = $urandom_range(32'hF000_0000, 0);
    windows[5].limit = windows[5].start + $urandom_range(1, 64) * PB + $urandom_range(PB - 1);

    foreach (windows[w]) begin
      phase = 2'(w / 2);
      settle();
      idle_pct = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      set_window(windows[w].start, windows[w].limit);
      if (windows[w].rebuild) push_item(OP_INIT, $urandom(), 1'b0, R_OK);
      if (w == 0) begin
        // drive one page into count saturation
        push_item(OP_ALLOC, $urandom(), 1'b0, R_OK);
        hot = frame_addr(live_frames[$]);
        repeat (258) push_item(OP_REF, hot, 1'b0, R_OK);
        repeat (3) push_item(OP_FREE, hot, 1'b0, R_OK);
      end
      repeat (windows[w].items) begin
        random_item(op, addr);
        push_item(op, addr, 1'b0, R_OK);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[files.f]
src/rpfa_pkg.sv
src/rpfa_ctrl.sv
src/rpfa_datapath.sv
src/refcounted_page_frame_allocator.sv
dv/refcounted_page_frame_allocator_tb.sv
